>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
// both macros take a label, clock, reset, antecedent and consequent
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/fltpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpm_pkg
// Sizes and constants of the four-level page table mapper.
// ----------------------------------------------------------------------------
package fltpm_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int ENTRIES     = 512;

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int FREE_W  = $clog2(TABLE_SLOTS + 1);
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int ADDR_W  = SLOT_W + IDX_W;
  localparam int DEPTH   = TABLE_SLOTS * ENTRIES;

  localparam int FRAME_W = 40;
  localparam int VA_W    = 48;
  localparam int FLAG_W  = 12;
  localparam int VPN_W   = 36;
  localparam int LEAF_W  = 52;
  localparam int ENTRY_W = 64;
  localparam int ADDED_W = 2;

  localparam logic [FRAME_W-1:0] POOL_BASE_RESET = FRAME_W'(256);
  localparam logic [FLAG_W-1:0]  TABLE_BITS      = FLAG_W'('h7);
  localparam logic [FLAG_W-1:0]  PRESENT         = FLAG_W'('h1);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

>>> sv/fltpm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpm request and response channels
// Valid/ready channels carrying map requests and their results.
// ----------------------------------------------------------------------------
interface fltpm_req_if;
  import fltpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] phys_frame;
  logic [VA_W-1:0]    virt_addr;
  logic [FLAG_W-1:0]  page_flags;

  modport source (output valid, output phys_frame, output virt_addr, output page_flags,
                  input ready);
  modport sink   (input valid, input phys_frame, input virt_addr, input page_flags,
                  output ready);
endinterface

interface fltpm_rsp_if;
  import fltpm_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [LEAF_W-1:0]  leaf_entry;
  logic [ADDED_W-1:0] tables_added;
  logic [VPN_W-1:0]   invalidate_page;

  modport source (output valid, output status, output leaf_entry, output tables_added,
                  output invalidate_page, input ready);
  modport sink   (input valid, input status, input leaf_entry, input tables_added,
                  input invalidate_page, output ready);
endinterface

>>> sv/four_level_page_table_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Maps one 4 KiB page per request into a local four-level table store.
// ----------------------------------------------------------------------------
// A request walks the root and the two tables below it, then writes the leaf,
// through one table memory with one write port and one registered read port,
// so each upper level passes through a read state and a check state. Each new
// table is zeroed one entry per cycle through the memory write port. After
// reset the root table is zeroed while req.ready stays low; configuration
// writes are taken at any time. The result sits in an output register, and a
// new request is taken once the block is back in idle, even while that result
// still waits on rsp.ready.
module four_level_page_table_mapper (
  input  logic                          clk,
  input  logic                          rst,
  fltpm_req_if.sink                     req,
  fltpm_rsp_if.source                   rsp,
  input  logic                          cfg_wr_en,
  input  logic [fltpm_pkg::FRAME_W-1:0] cfg_wr_data
);
  import fltpm_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_LEAF  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t             state;
  logic [FRAME_W-1:0] pool_base;
  logic [FREE_W-1:0]  next_free;
  logic [IDX_W-1:0]   clr_cnt;
  logic [1:0]         lvl;
  logic [SLOT_W-1:0]  slot;
  logic [ADDED_W-1:0] added;
  logic               res_status;

  logic [FRAME_W-1:0] frame;
  logic [VPN_W-1:0]   vpn;
  logic [FLAG_W-1:0]  flags;

  logic               rsp_valid;
  logic               rsp_status;
  logic [LEAF_W-1:0]  rsp_leaf;
  logic [ADDED_W-1:0] rsp_added;
  logic [VPN_W-1:0]   rsp_page;

  // table store
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [IDX_W-1:0]   idx;
  logic [FRAME_W-1:0] rel;
  logic               rel_ok;
  logic               out_of_slots;
  logic [SLOT_W-1:0]  fresh;
  logic [FRAME_W-1:0] fresh_frame;
  logic [LEAF_W-1:0]  leaf;
  logic               out_free;

  always_comb begin
    case (lvl)
      2'd0:    idx = vpn[4*IDX_W-1:3*IDX_W];
      2'd1:    idx = vpn[3*IDX_W-1:2*IDX_W];
      2'd2:    idx = vpn[2*IDX_W-1:IDX_W];
      default: idx = vpn[IDX_W-1:0];
    endcase
  end

  assign rd_addr      = {slot, idx};
  assign rel          = rd_data[LEAF_W-1:FLAG_W] - pool_base;
  assign rel_ok       = rel < FRAME_W'(TABLE_SLOTS);
  assign out_of_slots = next_free >= FREE_W'(TABLE_SLOTS);
  assign fresh        = next_free[SLOT_W-1:0];
  assign fresh_frame  = pool_base + FRAME_W'(fresh);
  assign leaf         = {frame, flags | PRESENT};
  assign out_free     = !rsp_valid || rsp.ready;

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = '0;
    unique case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = {SLOT_W'(0), clr_cnt};
      end
      S_CHECK: begin
        // link a fresh table into the current entry
        wr_en   = !rd_data[0] && !out_of_slots;
        wr_data = {(ENTRY_W - LEAF_W)'(0), fresh_frame, TABLE_BITS};
      end
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = {slot, clr_cnt};
      end
      S_LEAF: begin
        wr_en   = 1'b1;
        wr_data = {(ENTRY_W - LEAF_W)'(0), leaf};
      end
      S_IDLE, S_READ, S_DONE: begin
        wr_en = 1'b0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= POOL_BASE_RESET;
    end else if (cfg_wr_en) begin
      pool_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      next_free <= FREE_W'(1);
      clr_cnt   <= '0;
      lvl       <= '0;
      slot      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            frame      <= req.phys_frame;
            vpn        <= req.virt_addr[VA_W-1:FLAG_W];
            flags      <= req.page_flags;
            lvl        <= '0;
            slot       <= '0;
            added      <= '0;
            res_status <= STATUS_OK;
            state      <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_data[0]) begin
            if (rel_ok) begin
              slot  <= rel[SLOT_W-1:0];
              lvl   <= lvl + 2'd1;
              state <= (lvl == 2'd2) ? S_LEAF : S_READ;
            end else begin
              res_status <= STATUS_FAIL;
              state      <= S_DONE;
            end
          end else if (out_of_slots) begin
            res_status <= STATUS_FAIL;
            state      <= S_DONE;
          end else begin
            slot      <= fresh;
            next_free <= next_free + FREE_W'(1);
            added     <= added + ADDED_W'(1);
            clr_cnt   <= '0;
            state     <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == '1) begin
            lvl   <= lvl + 2'd1;
            state <= (lvl == 2'd2) ? S_LEAF : S_READ;
          end
        end
        S_LEAF: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // result word, loaded as the walk ends
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp_status <= res_status;
      rsp_added  <= added;
      rsp_leaf   <= (res_status == STATUS_OK) ? leaf : '0;
      rsp_page   <= (res_status == STATUS_OK) ? vpn : '0;
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.leaf_entry      = rsp_leaf;
  assign rsp.tables_added    = rsp_added;
  assign rsp.invalidate_page = rsp_page;

  `ASSERT_IMP(a_free_bound, clk, rst, 1'b1, next_free <= FREE_W'(TABLE_SLOTS))
  `ASSERT_IMP(a_fail_zero, clk, rst, rsp_valid && rsp_status == STATUS_FAIL, rsp_leaf == '0 && rsp_page == '0)
  `ASSERT_NXT(a_alloc_clear, clk, rst, state == S_CHECK && !rd_data[0] && !out_of_slots, state == S_CLEAR && clr_cnt == '0)
  `ASSERT_NXT(a_leaf_ok, clk, rst, state == S_LEAF, state == S_DONE && res_status == STATUS_OK)

endmodule
